// File: rtl/wildcard_byte_pattern_scan_assert.svh
// Assertion macros used by the checker of the byte pattern scanner.
`ifndef WILDCARD_BYTE_PATTERN_SCAN_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_ASSERT_SVH

// Property checked at every rising edge, switched off while reset is high.
`define WBPS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define WBPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/wbps_pkg.sv
package wbps_pkg;

   // Number of pattern positions held by the configuration registers.
   localparam int SLOTS = 32;
   // Width of the pattern length register.
   localparam int LEN_W = $clog2(SLOTS + 1);
   // Byte address width of the register port (registers on 8-byte steps).
   localparam int ADDR_W = 6;
   localparam int DATA_W = 64;
   localparam int IDX_W = 3;
   localparam int POS_W = $clog2(SLOTS);
   localparam int OFF_W = 32;

   // Register indexes.
   localparam logic [IDX_W-1:0] REG_PAT0 = 3'd0;
   localparam logic [IDX_W-1:0] REG_PAT1 = 3'd1;
   localparam logic [IDX_W-1:0] REG_PAT2 = 3'd2;
   localparam logic [IDX_W-1:0] REG_PAT3 = 3'd3;
   localparam logic [IDX_W-1:0] REG_WILD = 3'd4;
   localparam logic [IDX_W-1:0] REG_LEN  = 3'd5;

   // Pattern as the cells see it: position j lines up with the byte of age j.
   typedef struct packed {
      logic [SLOTS-1:0][7:0] pat;
      logic [SLOTS-1:0]      care;
      logic [LEN_W-1:0]      len;
      logic                  busy;
   } align_type;

   typedef struct packed {
      logic             found;
      logic [OFF_W-1:0] offset;
   } result_type;

endpackage

// File: rtl/wbps_if.sv
// Input channel: one byte of the region per transfer.
interface wbps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, data_byte, last_byte, input ready);
   modport sink (input valid, data_byte, last_byte, output ready);
endinterface

// Result channel: one transfer per region.
interface wbps_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [31:0] match_offset;

   modport source (output valid, found, match_offset, input ready);
   modport sink (input valid, found, match_offset, output ready);
endinterface

// File: rtl/wildcard_byte_pattern_scan.sv
// Wildcard byte pattern scanner. Bytes of a region arrive one per transfer,
// the last one flagged, and each region gives exactly one result: found with
// the offset of the first matching byte as soon as the first match completes,
// or not found on the last byte. The pattern (up to 32 bytes, each position
// optionally a wildcard) sits in the 64-bit register port at byte addresses
// 0, 8, 16, 24 (pattern bytes), 32 (wildcard mask) and 40 (length). A row of
// 32 byte cells shifts the stream and compares every position in parallel,
// so one byte is taken every cycle while the input is ready, and its result
// is registered. A skid register behind the output lets the next byte in
// while a result waits. The input is not ready in the cycle after reset and
// after each register write, while the lined-up pattern is refreshed.
module wildcard_byte_pattern_scan (
   input  logic                        clock,
   input  logic                        reset,
   wbps_req_if.sink                    req,
   wbps_rsp_if.source                  rsp,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [wbps_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [wbps_pkg::DATA_W-1:0] csr_pwdata,
   output logic [wbps_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready
);

   localparam logic [wbps_pkg::OFF_W-1:0] SEEN_MAX = '1;

   wbps_pkg::align_type                 align;
   logic [wbps_pkg::SLOTS-1:0][7:0]     chain;
   logic [wbps_pkg::SLOTS-1:0]          hit;
   logic                                accept;
   logic [wbps_pkg::OFF_W-1:0]          seen_ff;
   logic [wbps_pkg::OFF_W-1:0]          seen_in;
   logic [wbps_pkg::OFF_W-1:0]          seen_next;
   logic [wbps_pkg::OFF_W-1:0]          len_ext;
   logic                                reported_ff;
   logic                                reported_in;
   logic                                match;
   logic                                has_res;
   wbps_pkg::result_type                res;
   logic                                out_valid_ff;
   wbps_pkg::result_type                out_ff;
   logic                                skid_valid_ff;
   wbps_pkg::result_type                skid_ff;
   logic                                out_free;

   wbps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .align       (align)
   );

   assign req.ready = !skid_valid_ff && !align.busy;
   assign accept = req.valid && req.ready;

   // Row of byte cells; cell j compares the byte of age j.
   for (genvar j = 0; j < wbps_pkg::SLOTS; j++) begin : g_cell
      logic [7:0] byte_in;
      if (j == 0) begin : g_head
         assign byte_in = req.data_byte;
      end else begin : g_link
         assign byte_in = chain[j-1];
      end
      wbps_cell u_cell (
         .clock    (clock),
         .shift_en (accept),
         .byte_in  (byte_in),
         .pat_byte (align.pat[j]),
         .care     (align.care[j]),
         .byte_out (chain[j]),
         .hit      (hit[j])
      );
   end

   // Region counter and match decision for the incoming byte.
   assign seen_next = (seen_ff == SEEN_MAX) ? seen_ff : seen_ff + 1'b1;
   assign len_ext = wbps_pkg::OFF_W'(align.len);
   assign match = !reported_ff && (align.len != '0) && (seen_next >= len_ext) && (&hit);
   assign has_res = match || (req.last_byte && !reported_ff);
   assign res.found = match;
   assign res.offset = match ? (seen_next - len_ext) : '0;
   assign seen_in = req.last_byte ? '0 : seen_next;
   assign reported_in = req.last_byte ? 1'b0 : (reported_ff || match);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= '0;
         reported_ff <= 1'b0;
      end else if (accept) begin
         seen_ff     <= seen_in;
         reported_ff <= reported_in;
      end
   end

   // Output register with a skid register behind it.
   assign out_free = !out_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end else if (accept && has_res) begin
            out_valid_ff <= 1'b1;
            out_ff       <= res;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end else if (accept && has_res) begin
         skid_valid_ff <= 1'b1;
         skid_ff       <= res;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.found = out_ff.found;
   assign rsp.match_offset = out_ff.offset;

endmodule

// File: rtl/wbps_cell.sv
module wbps_cell (
   input  logic       clock,
   input  logic       shift_en,
   input  logic [7:0] byte_in,
   input  logic [7:0] pat_byte,
   input  logic       care,
   output logic [7:0] byte_out,
   output logic       hit
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in_d;

   // The cell compares the byte it is about to take, so a match is known
   // in the same cycle that the byte arrives.
   assign hit = !care || (byte_in == pat_byte);

   assign byte_in_d = shift_en ? byte_in : byte_ff;

   // Held byte, passed on to the next older cell.
   always_ff @(posedge clock) begin
      byte_ff <= byte_in_d;
   end

   assign byte_out = byte_ff;

endmodule

// File: rtl/wbps_csr.sv
module wbps_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [wbps_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [wbps_pkg::DATA_W-1:0] csr_pwdata,
   output logic [wbps_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready,
   output wbps_pkg::align_type         align
);

   logic [3:0][63:0]                  pat_ff;
   logic [31:0]                       wild_ff;
   logic [wbps_pkg::LEN_W-1:0]        len_ff;
   logic [wbps_pkg::SLOTS-1:0][7:0]   pat_bytes;
   logic [wbps_pkg::LEN_W-1:0]        eff_len;
   logic [wbps_pkg::IDX_W-1:0]        reg_idx;
   logic                              wr;
   wbps_pkg::align_type               align_ff;
   wbps_pkg::align_type               align_in;

   assign csr_pready = 1'b1;
   assign reg_idx = csr_paddr[wbps_pkg::ADDR_W-1:3];
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign pat_bytes = pat_ff;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff  <= '0;
         wild_ff <= '0;
         len_ff  <= '0;
      end else if (wr) begin
         case (reg_idx)
            wbps_pkg::REG_PAT0: pat_ff[0] <= csr_pwdata;
            wbps_pkg::REG_PAT1: pat_ff[1] <= csr_pwdata;
            wbps_pkg::REG_PAT2: pat_ff[2] <= csr_pwdata;
            wbps_pkg::REG_PAT3: pat_ff[3] <= csr_pwdata;
            wbps_pkg::REG_WILD: wild_ff <= csr_pwdata[31:0];
            wbps_pkg::REG_LEN:  len_ff <= csr_pwdata[wbps_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Register reads.
   always_comb begin
      case (reg_idx)
         wbps_pkg::REG_PAT0: csr_prdata = pat_ff[0];
         wbps_pkg::REG_PAT1: csr_prdata = pat_ff[1];
         wbps_pkg::REG_PAT2: csr_prdata = pat_ff[2];
         wbps_pkg::REG_PAT3: csr_prdata = pat_ff[3];
         wbps_pkg::REG_WILD: csr_prdata = {32'd0, wild_ff};
         wbps_pkg::REG_LEN:  csr_prdata = {{(wbps_pkg::DATA_W - wbps_pkg::LEN_W){1'b0}}, len_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // A length above the number of slots counts as a full pattern.
   assign eff_len = (len_ff > wbps_pkg::LEN_W'(wbps_pkg::SLOTS)) ?
                    wbps_pkg::LEN_W'(wbps_pkg::SLOTS) : len_ff;

   // Reverse the pattern so that the last position in use meets the newest
   // byte; cells beyond the length are masked out.
   always_comb begin
      logic [wbps_pkg::POS_W-1:0] pos;
      pos = '0;
      for (int j = 0; j < wbps_pkg::SLOTS; j++) begin
         if (wbps_pkg::LEN_W'(j) < eff_len) begin
            pos = wbps_pkg::POS_W'(eff_len - wbps_pkg::LEN_W'(1) - wbps_pkg::LEN_W'(j));
            align_in.pat[j]  = pat_bytes[pos];
            align_in.care[j] = !wild_ff[pos];
         end else begin
            align_in.pat[j]  = '0;
            align_in.care[j] = 1'b0;
         end
      end
      align_in.len  = eff_len;
      align_in.busy = wr;
   end

   // The lined-up pattern is refreshed every cycle; busy covers the cycle
   // after a write or reset while it settles.
   always_ff @(posedge clock) begin
      align_ff.pat  <= align_in.pat;
      align_ff.care <= align_in.care;
      align_ff.len  <= align_in.len;
      if (reset) begin
         align_ff.busy <= 1'b1;
      end else begin
         align_ff.busy <= align_in.busy;
      end
   end

   assign align = align_ff;

endmodule

// File: rtl/wbps_checker.sv
`include "wildcard_byte_pattern_scan_assert.svh"

module wbps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_found,
   input logic [31:0] rsp_match_offset,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite
);

   // A result waiting to be taken stays offered.
   `WBPS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")

   // A not-found result always carries offset zero.
   `WBPS_ASSERT(a_miss_zero, clock, reset, rsp_valid && !rsp_found |-> rsp_match_offset == 32'd0, "not-found result with non-zero offset")

   // The input pauses for the cycle after a register write.
   `WBPS_ASSERT(a_cfg_pause, clock, reset, csr_psel && csr_penable && csr_pwrite |=> !req_ready, "input ready straight after a register write")

   // Reset leaves no result on offer.
   `WBPS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result offered after reset")

endmodule

bind wildcard_byte_pattern_scan wbps_checker u_wbps_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_found        (rsp.found),
   .rsp_match_offset (rsp.match_offset),
   .csr_psel         (csr_psel),
   .csr_penable      (csr_penable),
   .csr_pwrite       (csr_pwrite)
);
